### sv/masg_pkg.sv
// Shared types and constants for the multi-axis step generator.
// No dependencies; every other file refers to it by scoped names.
package masg_pkg;

  // Item opcodes; the fourth code is unused and has no effect.
  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_SET  = 2'd1,
    OP_MOVE = 2'd2
  } opcode_e;

  // Configuration register indexes
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_START_RATE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RATE   = 4'd1;

  // Register reset values
  localparam int START_RATE_RESET = 100;
  localparam int MIN_RATE_RESET   = 8;

  // Accel/decel span is a quarter of the move: total >> 2
  localparam int PLAN_SHIFT = 2;

  // Fixed field widths of the channels
  localparam int FIELD_W  = 32;
  localparam int OUT_AXES = 4;
  localparam int MAX_AXES = 8;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [FIELD_W-1:0] target_x;
    logic [FIELD_W-1:0] target_y;
    logic [FIELD_W-1:0] target_z;
    logic [FIELD_W-1:0] target_e;
  } item_t;

  // Per-item command from the control logic to every axis
  typedef struct packed {
    logic set_pos;
    logic start_move;
    logic do_step;
  } axis_cmd_t;

endpackage

### sv/masg_ifs.sv
// Channel interfaces of the multi-axis step generator: item, result and config write.
// Depends on masg_pkg for the field widths and the register index width.
interface masg_item_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    opcode;
  logic [masg_pkg::FIELD_W-1:0]  target_x;
  logic [masg_pkg::FIELD_W-1:0]  target_y;
  logic [masg_pkg::FIELD_W-1:0]  target_z;
  logic [masg_pkg::FIELD_W-1:0]  target_e;

  modport source (output valid, opcode, target_x, target_y, target_z, target_e,
                  input ready);
  modport sink (input valid, opcode, target_x, target_y, target_z, target_e,
                output ready);
endinterface

interface masg_res_if;
  logic                          valid;
  logic                          ready;
  logic [3:0]                    step_bits;
  logic [3:0]                    dir_bits;
  logic                          busy_res;
  logic [masg_pkg::FIELD_W-1:0]  pos_x;
  logic [masg_pkg::FIELD_W-1:0]  pos_y;
  logic [masg_pkg::FIELD_W-1:0]  pos_z;
  logic [masg_pkg::FIELD_W-1:0]  pos_e;

  modport source (output valid, step_bits, dir_bits, busy_res, pos_x, pos_y, pos_z,
                  pos_e, input ready);
  modport sink (input valid, step_bits, dir_bits, busy_res, pos_x, pos_y, pos_z,
                pos_e, output ready);
endinterface

interface masg_cfg_if #(
  parameter int DATA_W = 16
);
  logic                            valid;
  logic                            ready;
  logic [masg_pkg::CFG_IDX_W-1:0]  index;
  logic [DATA_W-1:0]               data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### sv/masg_in_stage.sv
// Input register of the step generator: holds one word until the state update takes it.
// Depends on masg_pkg (item_t) and masg_item_if.
module masg_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  masg_item_if.sink         item_i,
  input  logic              adv_i,
  output logic              valid_o,
  output masg_pkg::item_t   item_o
);

  logic            valid_q, valid_d;
  masg_pkg::item_t data_q, data_d;
  logic            accept;

  // Free when empty or when the held word moves on this cycle
  assign item_i.ready = !valid_q || adv_i;
  assign accept       = item_i.valid && item_i.ready;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (accept) begin
      valid_d         = 1'b1;
      data_d.opcode   = item_i.opcode;
      data_d.target_x = item_i.target_x;
      data_d.target_y = item_i.target_y;
      data_d.target_z = item_i.target_z;
      data_d.target_e = item_i.target_e;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign item_o  = data_q;

endmodule

### sv/masg_axis.sv
// One axis: position, delta, Bresenham error term and direction.
// Depends on masg_pkg (axis_cmd_t).
module masg_axis #(
  parameter int POS_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  masg_pkg::axis_cmd_t      cmd_i,
  input  logic [POS_WIDTH-1:0]     target_i,
  input  logic [POS_WIDTH-1:0]     total_i,
  output logic [POS_WIDTH-1:0]     move_delta_o,
  output logic                     step_o,
  output logic                     dir_o,
  output logic [POS_WIDTH-1:0]     pos_o
);

  localparam int ERR_W = POS_WIDTH + 1;

  logic [POS_WIDTH-1:0] pos_q, pos_d;
  logic [POS_WIDTH-1:0] delta_q, delta_d;
  logic [ERR_W-1:0]     err_q, err_d;
  logic                 dir_q, dir_d;

  logic                 fwd;
  logic [POS_WIDTH-1:0] diff_fwd, diff_rev, new_delta;
  logic [ERR_W-1:0]     err_sum;
  logic [ERR_W:0]       err_sub;
  logic                 take_step;

  // Move planning: magnitude of target - position, both orders in parallel
  assign fwd       = $signed(target_i) >= $signed(pos_q);
  assign diff_fwd  = target_i - pos_q;
  assign diff_rev  = pos_q - target_i;
  assign new_delta = fwd ? diff_fwd : diff_rev;

  // Bresenham: add delta, step once the sum reaches the major-axis count
  assign err_sum   = err_q + ERR_W'(delta_q);
  assign err_sub   = {1'b0, err_sum} - (ERR_W + 1)'(total_i);
  assign take_step = cmd_i.do_step && (delta_q != '0) && !err_sub[ERR_W];

  always_comb begin
    pos_d   = pos_q;
    delta_d = delta_q;
    err_d   = err_q;
    dir_d   = dir_q;
    if (cmd_i.set_pos) begin
      pos_d = target_i;
    end else if (cmd_i.start_move) begin
      delta_d = new_delta;
      dir_d   = fwd;
      err_d   = '0;
    end else if (cmd_i.do_step && (delta_q != '0)) begin
      if (take_step) begin
        err_d = err_sub[ERR_W-1:0];
        pos_d = dir_q ? pos_q + POS_WIDTH'(1) : pos_q - POS_WIDTH'(1);
      end else begin
        err_d = err_sum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      delta_q <= '0;
      err_q   <= '0;
      dir_q   <= 1'b1;
    end else begin
      pos_q   <= pos_d;
      delta_q <= delta_d;
      err_q   <= err_d;
      dir_q   <= dir_d;
    end
  end

  assign move_delta_o = new_delta;
  assign step_o       = take_step;
  assign dir_o        = dir_d;
  assign pos_o        = pos_d;

endmodule

### sv/masg_timing.sv
// Move control: config registers, step count, trapezoid period and tick divider.
// Depends on masg_pkg (register indexes, reset values) and masg_cfg_if.
module masg_timing #(
  parameter int POS_WIDTH  = 32,
  parameter int RATE_WIDTH = 16,
  parameter int AXIS_COUNT = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  masg_cfg_if.sink              cfg_i,
  input  logic                  tick_i,
  input  logic                  move_i,
  input  logic [POS_WIDTH-1:0]  move_delta_i [AXIS_COUNT],
  output logic                  step_o,
  output logic [POS_WIDTH-1:0]  total_o,
  output logic                  busy_o
);

  localparam logic [RATE_WIDTH-1:0] RateMax = {RATE_WIDTH{1'b1}};

  logic [RATE_WIDTH-1:0] start_rate_q, min_rate_q;
  logic [POS_WIDTH-1:0]  total_q, total_d;
  logic [POS_WIDTH-1:0]  remaining_q, remaining_d;
  logic [POS_WIDTH-1:0]  phase_q, phase_d;
  logic [RATE_WIDTH-1:0] period_q, period_d;
  logic [RATE_WIDTH-1:0] tick_q, tick_d;

  logic [POS_WIDTH-1:0]  lvl0 [masg_pkg::MAX_AXES];
  logic [POS_WIDTH-1:0]  lvl1 [masg_pkg::MAX_AXES/2];
  logic [POS_WIDTH-1:0]  lvl2 [masg_pkg::MAX_AXES/4];
  logic [POS_WIDTH-1:0]  max_delta;

  logic [RATE_WIDTH-1:0] tick_inc;
  logic [POS_WIDTH-1:0]  phase_inc, rem_dec, accel;
  logic                  active, step;

  // Config writes are always taken
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_rate_q <= RATE_WIDTH'(masg_pkg::START_RATE_RESET);
      min_rate_q   <= RATE_WIDTH'(masg_pkg::MIN_RATE_RESET);
    end else if (cfg_i.valid) begin
      if (cfg_i.index == masg_pkg::CFG_START_RATE) begin
        start_rate_q <= RATE_WIDTH'(cfg_i.data);
      end
      if (cfg_i.index == masg_pkg::CFG_MIN_RATE) begin
        min_rate_q <= RATE_WIDTH'(cfg_i.data);
      end
    end
  end

  // Largest delta over the axes: three-level compare tree, absent axes read zero
  for (genvar a = 0; a < masg_pkg::MAX_AXES; a++) begin : g_pad
    if (a < AXIS_COUNT) begin : g_real
      assign lvl0[a] = move_delta_i[a];
    end else begin : g_zero
      assign lvl0[a] = '0;
    end
  end

  always_comb begin
    for (int i = 0; i < masg_pkg::MAX_AXES / 2; i++) begin
      lvl1[i] = (lvl0[2*i] > lvl0[2*i+1]) ? lvl0[2*i] : lvl0[2*i+1];
    end
    for (int i = 0; i < masg_pkg::MAX_AXES / 4; i++) begin
      lvl2[i] = (lvl1[2*i] > lvl1[2*i+1]) ? lvl1[2*i] : lvl1[2*i+1];
    end
    max_delta = (lvl2[0] > lvl2[1]) ? lvl2[0] : lvl2[1];
  end

  // Tick divider and step bookkeeping
  assign active    = remaining_q != '0;
  assign tick_inc  = tick_q + RATE_WIDTH'(1);
  assign step      = tick_i && active && !(tick_inc < period_q);
  assign phase_inc = phase_q + POS_WIDTH'(1);
  assign rem_dec   = remaining_q - POS_WIDTH'(1);
  assign accel     = total_q >> masg_pkg::PLAN_SHIFT;

  always_comb begin
    total_d     = total_q;
    remaining_d = remaining_q;
    phase_d     = phase_q;
    period_d    = period_q;
    tick_d      = tick_q;
    if (move_i) begin
      total_d     = max_delta;
      remaining_d = max_delta;
      phase_d     = '0;
      period_d    = start_rate_q;
      tick_d      = '0;
    end else if (tick_i && active) begin
      if (!step) begin
        tick_d = tick_inc;
      end else begin
        tick_d      = '0;
        phase_d     = phase_inc;
        remaining_d = rem_dec;
        // Decel zone starts where phase reaches total - accel,
        // i.e. where the remaining count falls to accel
        if (phase_inc < accel) begin
          if (period_q > min_rate_q) begin
            period_d = period_q - RATE_WIDTH'(1);
          end
        end else if (rem_dec <= accel) begin
          if (period_q != RateMax) begin
            period_d = period_q + RATE_WIDTH'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      remaining_q <= '0;
      phase_q     <= '0;
      period_q    <= RATE_WIDTH'(masg_pkg::START_RATE_RESET);
      tick_q      <= '0;
    end else begin
      total_q     <= total_d;
      remaining_q <= remaining_d;
      phase_q     <= phase_d;
      period_q    <= period_d;
      tick_q      <= tick_d;
    end
  end

  assign step_o  = step;
  assign total_o = total_q;
  assign busy_o  = remaining_d != '0;

endmodule

### sv/multi_axis_step_generator.sv
// Top level of the multi-axis step generator: input register, axes, move control, result register.
// Depends on masg_pkg, the channel interfaces, masg_in_stage, masg_axis and masg_timing.
//
//  channel  dir  handshake      word
//  item_i   in   valid/ready    opcode, target_x/y/z/e
//  res_o    out  valid/ready    step_bits, dir_bits, busy_res, pos_x/y/z/e
//  cfg_i    in   valid/ready    index, data (start_rate, min_rate); ready always high
//
// One word per cycle sustained while the result side takes results; a result passes through
// the input register, then the state update into the result register.
// The state update logic for every opcode is bounded by the move path (subtract, delta
// compare tree) and the tick path (error add and subtract).
// Reset clears all control state and loads the register reset values.
// A stalled result holds; the input register keeps taking words while it can move on.
module multi_axis_step_generator #(
  parameter int POS_WIDTH  = 32,
  parameter int RATE_WIDTH = 16,
  parameter int AXIS_COUNT = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  masg_item_if.sink   item_i,
  masg_res_if.source  res_o,
  masg_cfg_if.sink    cfg_i
);

  localparam int FW = masg_pkg::FIELD_W;

  logic                 in_valid, adv;
  masg_pkg::item_t      in_item;
  logic                 is_tick, is_set, is_move;
  masg_pkg::axis_cmd_t  cmd;

  logic [FW-1:0]        in_tgt [masg_pkg::OUT_AXES];
  logic [POS_WIDTH-1:0] tgt [AXIS_COUNT];
  logic [POS_WIDTH-1:0] move_delta [AXIS_COUNT];
  logic [POS_WIDTH-1:0] pos_d [AXIS_COUNT];
  logic [AXIS_COUNT-1:0] step_d, dir_d;
  logic [POS_WIDTH-1:0] total;
  logic                 tim_step, busy_d;

  logic [3:0]           step_bits_d, dir_bits_d;
  logic [FW-1:0]        pos_out_d [masg_pkg::OUT_AXES];

  logic                 res_vld_q, res_vld_d;
  logic [3:0]           step_bits_q, dir_bits_q;
  logic                 busy_q;
  logic [FW-1:0]        pos_out_q [masg_pkg::OUT_AXES];

  // Input register
  masg_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_i),
    .adv_i   (adv),
    .valid_o (in_valid),
    .item_o  (in_item)
  );

  // Held word moves into the result register when that is free or drains
  assign adv     = in_valid && (!res_vld_q || res_o.ready);
  assign is_tick = adv && (in_item.opcode == masg_pkg::OP_TICK);
  assign is_set  = adv && (in_item.opcode == masg_pkg::OP_SET);
  assign is_move = adv && (in_item.opcode == masg_pkg::OP_MOVE);

  assign cmd.set_pos    = is_set;
  assign cmd.start_move = is_move;
  assign cmd.do_step    = tim_step;

  // Per-axis targets; axes past the fourth take zero
  assign in_tgt[0] = in_item.target_x;
  assign in_tgt[1] = in_item.target_y;
  assign in_tgt[2] = in_item.target_z;
  assign in_tgt[3] = in_item.target_e;

  for (genvar a = 0; a < AXIS_COUNT; a++) begin : g_axis
    if (a < masg_pkg::OUT_AXES) begin : g_tgt
      assign tgt[a] = POS_WIDTH'($signed(in_tgt[a]));
    end else begin : g_none
      assign tgt[a] = '0;
    end

    masg_axis #(
      .POS_WIDTH (POS_WIDTH)
    ) u_axis (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .target_i     (tgt[a]),
      .total_i      (total),
      .move_delta_o (move_delta[a]),
      .step_o       (step_d[a]),
      .dir_o        (dir_d[a]),
      .pos_o        (pos_d[a])
    );
  end

  masg_timing #(
    .POS_WIDTH  (POS_WIDTH),
    .RATE_WIDTH (RATE_WIDTH),
    .AXIS_COUNT (AXIS_COUNT)
  ) u_timing (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_i),
    .tick_i       (is_tick),
    .move_i       (is_move),
    .move_delta_i (move_delta),
    .step_o       (tim_step),
    .total_o      (total),
    .busy_o       (busy_d)
  );

  // Result fields; absent axes read zero
  for (genvar a = 0; a < masg_pkg::OUT_AXES; a++) begin : g_out
    if (a < AXIS_COUNT) begin : g_real
      assign step_bits_d[a] = step_d[a];
      assign dir_bits_d[a]  = dir_d[a];
      assign pos_out_d[a]   = FW'($signed(pos_d[a]));
    end else begin : g_zero
      assign step_bits_d[a] = 1'b0;
      assign dir_bits_d[a]  = 1'b0;
      assign pos_out_d[a]   = '0;
    end
  end

  // Result register
  always_comb begin
    res_vld_d = res_vld_q;
    if (adv) begin
      res_vld_d = 1'b1;
    end else if (res_o.ready) begin
      res_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      step_bits_q <= step_bits_d;
      dir_bits_q  <= dir_bits_d;
      busy_q      <= busy_d;
      pos_out_q   <= pos_out_d;
    end
  end

  assign res_o.valid     = res_vld_q;
  assign res_o.step_bits = step_bits_q;
  assign res_o.dir_bits  = dir_bits_q;
  assign res_o.busy_res  = busy_q;
  assign res_o.pos_x     = pos_out_q[0];
  assign res_o.pos_y     = pos_out_q[1];
  assign res_o.pos_z     = pos_out_q[2];
  assign res_o.pos_e     = pos_out_q[3];

  // An axis only steps on a move step of the controller
  a_step_needs_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_d != '0) |-> tim_step)
    else $error("axis stepped without a move step");

  // Move steps only come from tick words
  a_step_on_tick_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tim_step |-> is_tick)
    else $error("move step on a non-tick word");

  // A move word reports no step pulses
  a_move_no_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_move |=> (res_vld_q && (step_bits_q == 4'd0)))
    else $error("move result carries step bits");

endmodule

### tb/sv/masg_step_checker.sv
// Checker for the multi-axis step generator: watches the item, result and config channels.
// Depends on masg_pkg and the channel interfaces; keeps its own copy of the motion state.
module masg_step_checker (
  input  logic    clk_i,
  input  logic    rst_ni,
  masg_item_if    item_mon,
  masg_res_if     res_mon,
  masg_cfg_if     cfg_mon,
  output int      fail_count_o,
  output int      pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [3:0]  step_bits;
    logic [3:0]  dir_bits;
    logic        busy;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] pos_e;
  } status_t;

  // register copies
  logic [15:0] start_rate;
  logic [15:0] min_rate;

  // motion state
  logic [31:0] axis_pos   [4];
  logic [31:0] axis_delta [4];
  logic [32:0] axis_err   [4];
  logic [3:0]  axis_fwd;
  logic [31:0] total_steps;
  logic [31:0] steps_left;
  logic [31:0] steps_done;
  logic [31:0] accel_span;
  logic [31:0] decel_from;
  logic [15:0] step_period;
  logic [15:0] tick_cnt;

  status_t       status_q [$];
  status_t       status_new;
  status_t       status_want;
  masg_pkg::item_t word_in;
  int            fail_count = 0;

  assign fail_count_o = fail_count;

  // Advance the motion state by one word and build the status it reports
  task automatic apply_word(input masg_pkg::item_t w, output status_t s);
    logic [31:0]        tgt [4];
    logic signed [32:0] diff;
    logic [32:0]        mag;
    logic [3:0]         stepped;
    stepped = '0;
    tgt[0] = w.target_x;
    tgt[1] = w.target_y;
    tgt[2] = w.target_z;
    tgt[3] = w.target_e;
    case (w.opcode)
      masg_pkg::OP_TICK: begin
        // idle ticks leave everything alone
        if (steps_left != 0) begin
          tick_cnt = tick_cnt + 16'd1;
          if (tick_cnt >= step_period) begin
            tick_cnt = '0;
            for (int a = 0; a < 4; a++) begin
              if (axis_delta[a] != 0) begin
                axis_err[a] = axis_err[a] + {1'b0, axis_delta[a]};
                if (axis_err[a] >= {1'b0, total_steps}) begin
                  axis_err[a] = axis_err[a] - {1'b0, total_steps};
                  stepped[a] = 1'b1;
                  axis_pos[a] = axis_fwd[a] ? axis_pos[a] + 32'd1 : axis_pos[a] - 32'd1;
                end
              end
            end
            steps_done = steps_done + 32'd1;
            steps_left = steps_left - 32'd1;
            // trapezoid: speed up with a floor, slow down with saturation
            if (steps_done < accel_span) begin
              if (step_period > min_rate) step_period = step_period - 16'd1;
            end else if (steps_done >= decel_from) begin
              if (step_period != 16'hFFFF) step_period = step_period + 16'd1;
            end
          end
        end
      end
      masg_pkg::OP_SET: begin
        for (int a = 0; a < 4; a++) axis_pos[a] = tgt[a];
      end
      masg_pkg::OP_MOVE: begin
        total_steps = '0;
        for (int a = 0; a < 4; a++) begin
          diff = $signed({tgt[a][31], tgt[a]}) - $signed({axis_pos[a][31], axis_pos[a]});
          axis_fwd[a] = ~diff[32];
          mag = diff[32] ? (~diff + 33'd1) : diff;
          axis_delta[a] = mag[31:0];
          axis_err[a] = '0;
          if (axis_delta[a] > total_steps) total_steps = axis_delta[a];
        end
        steps_left  = total_steps;
        accel_span  = total_steps >> masg_pkg::PLAN_SHIFT;
        decel_from  = total_steps - accel_span;
        step_period = start_rate;
        tick_cnt    = '0;
        steps_done  = '0;
      end
      default: begin
        // unused code: status only
      end
    endcase
    s.step_bits = stepped;
    s.dir_bits  = axis_fwd;
    s.busy      = (steps_left != 0);
    s.pos_x     = axis_pos[0];
    s.pos_y     = axis_pos[1];
    s.pos_z     = axis_pos[2];
    s.pos_e     = axis_pos[3];
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Predict on each accepted word, compare each accepted result with the oldest status
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_rate  = 16'(masg_pkg::START_RATE_RESET);
      min_rate    = 16'(masg_pkg::MIN_RATE_RESET);
      for (int a = 0; a < 4; a++) begin
        axis_pos[a]   = '0;
        axis_delta[a] = '0;
        axis_err[a]   = '0;
      end
      axis_fwd    = '1;
      total_steps = '0;
      steps_left  = '0;
      steps_done  = '0;
      accel_span  = '0;
      decel_from  = '0;
      step_period = 16'(masg_pkg::START_RATE_RESET);
      tick_cnt    = '0;
      status_q.delete();
      pending_o  <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          masg_pkg::CFG_START_RATE: start_rate = cfg_mon.data;
          masg_pkg::CFG_MIN_RATE:   min_rate   = cfg_mon.data;
          default: ;
        endcase
      end
      if (item_mon.valid && item_mon.ready) begin
        word_in.opcode   = item_mon.opcode;
        word_in.target_x = item_mon.target_x;
        word_in.target_y = item_mon.target_y;
        word_in.target_z = item_mon.target_z;
        word_in.target_e = item_mon.target_e;
        apply_word(word_in, status_new);
        status_q.push_back(status_new);
      end
      if (res_mon.valid && res_mon.ready) begin
        if (status_q.size() == 0) begin
          $display("%0t ns: result with no status pending, actual steps %h pos_x %h",
                   $time, res_mon.step_bits, res_mon.pos_x);
          fail_count++;
        end else begin
          status_want = status_q.pop_front();
          check_field("step_bits", 32'(status_want.step_bits), 32'(res_mon.step_bits));
          check_field("dir_bits",  32'(status_want.dir_bits),  32'(res_mon.dir_bits));
          check_field("busy_res",  32'(status_want.busy),      32'(res_mon.busy_res));
          check_field("pos_x",     status_want.pos_x,          res_mon.pos_x);
          check_field("pos_y",     status_want.pos_y,          res_mon.pos_y);
          check_field("pos_z",     status_want.pos_z,          res_mon.pos_z);
          check_field("pos_e",     status_want.pos_e,          res_mon.pos_e);
        end
      end
      pending_o <= status_q.size();
    end
  end

endmodule

### tb/sv/testbench.sv
// Top of the step generator testbench: clock, reset, stimulus on the item and config channels.
// Depends on masg_pkg, the channel interfaces, masg_step_checker and the block itself.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam int         HOLD_CYC   = 80;
  localparam int         TICK_CAP   = 600;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  masg_item_if                 item_if ();
  masg_res_if                  res_if ();
  masg_cfg_if #(.DATA_W(16))   cfg_if ();

  int   fail_count;
  int   pending;
  int   tx_idle_pct  = 0;
  int   rx_stall_pct = 0;
  int   hold_tokens  = 0;
  int   sent_count   = 0;
  int   rx_count     = 0;
  int   cfg_writes   = 0;
  logic last_busy    = 1'b0;
  logic [31:0] base [4];
  logic [31:0] tgt  [4];

  multi_axis_step_generator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  masg_step_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_mon     (item_if),
    .res_mon      (res_if),
    .cfg_mon      (cfg_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #6 clk_i = ~clk_i;

  // Run-time guard
  initial begin
    #5_000_000;
    $display("FAIL multi_axis_step_generator");
    $finish;
  end

  // Result side: random stalls plus long hold-offs on request
  initial begin
    int hold_left;
    int holds_done;
    hold_left  = 0;
    holds_done = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else if (hold_tokens != holds_done) begin
        holds_done++;
        hold_left = HOLD_CYC - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Track the latest reported busy flag to know when a move has run out
  always @(posedge clk_i) begin
    if (res_if.valid && res_if.ready) begin
      rx_count  <= rx_count + 1;
      last_busy <= res_if.busy_res;
    end
  end

  task automatic push_word(input logic [1:0] op, input logic [31:0] x, input logic [31:0] y,
                           input logic [31:0] z, input logic [31:0] e);
    while ($urandom_range(99) < tx_idle_pct) begin
      item_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_if.valid    <= 1'b1;
    item_if.opcode   <= op;
    item_if.target_x <= x;
    item_if.target_y <= y;
    item_if.target_z <= z;
    item_if.target_e <= e;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    sent_count++;
  endtask

  task automatic tick_some(input int n);
    repeat (n) push_word(masg_pkg::OP_TICK, $urandom, $urandom, $urandom, $urandom);
  endtask

  // Tick until a status after the last word reports the move finished
  task automatic tick_until_idle(input int cap);
    int mark;
    int n;
    mark = sent_count;
    n    = 0;
    do begin
      push_word(masg_pkg::OP_TICK, $urandom, $urandom, $urandom, $urandom);
      n++;
    end while (!(rx_count > mark && !last_busy) && n < cap);
  endtask

  task automatic write_reg(input logic [masg_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_writes++;
  endtask

  // Registers change only once every status is back and the pipe has emptied
  task automatic configure(input logic [15:0] start_val, input logic [15:0] min_val);
    item_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
    write_reg(masg_pkg::CFG_START_RATE, start_val);
    write_reg(masg_pkg::CFG_MIN_RATE, min_val);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_idling(input int phase);
    case (phase)
      0: begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
      1: begin tx_idle_pct = 72; rx_stall_pct <= 0;  end
      2: begin tx_idle_pct = 0;  rx_stall_pct <= 72; end
      default: begin tx_idle_pct = 11; rx_stall_pct <= 11; end
    endcase
  endtask

  // Set random positions, then aim a short move at an offset of them
  task automatic short_move(input int span);
    int d;
    for (int a = 0; a < 4; a++) base[a] = $urandom;
    push_word(masg_pkg::OP_SET, base[0], base[1], base[2], base[3]);
    for (int a = 0; a < 4; a++) begin
      d = int'($urandom_range(2 * span)) - span;
      tgt[a] = base[a] + 32'(d);
    end
    push_word(masg_pkg::OP_MOVE, tgt[0], tgt[1], tgt[2], tgt[3]);
  endtask

  // Random part: mostly complete moves, some interrupted, some noise
  task automatic run_block(input int n_items);
    int first;
    int r;
    first = sent_count;
    while (sent_count - first < n_items) begin
      r = $urandom_range(99);
      if (r < 60) begin
        short_move(($urandom_range(9) == 0) ? 24 : 6);
        if ($urandom_range(4) == 0) begin
          tick_some($urandom_range(40, 1));
          if ($urandom_range(1) == 0)
            push_word(masg_pkg::OP_SET, $urandom, $urandom, $urandom, $urandom);
          else
            short_move(5);
        end
        tick_until_idle(TICK_CAP);
      end else if (r < 75) begin
        push_word(2'($urandom_range(3)), $urandom, $urandom, $urandom, $urandom);
      end else if (r < 90) begin
        push_word(masg_pkg::OP_MOVE, $urandom, $urandom, $urandom, $urandom);
        tick_some($urandom_range(30, 5));
        if ($urandom_range(1) == 0) push_word(OP_UNUSED, $urandom, $urandom, $urandom, $urandom);
        push_word(masg_pkg::OP_SET, $urandom, $urandom, $urandom, $urandom);
      end else begin
        tick_some($urandom_range(10, 1));
      end
    end
  endtask

  initial begin
    item_if.valid    <= 1'b0;
    item_if.opcode   <= masg_pkg::OP_TICK;
    item_if.target_x <= '0;
    item_if.target_y <= '0;
    item_if.target_z <= '0;
    item_if.target_e <= '0;
    cfg_if.valid     <= 1'b0;
    cfg_if.index     <= masg_pkg::CFG_START_RATE;
    cfg_if.data      <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset registers, idle tick, unused code, extreme positions, zero move
    push_word(masg_pkg::OP_TICK, '0, '0, '0, '0);
    push_word(OP_UNUSED, '1, '1, '1, '1);
    push_word(masg_pkg::OP_SET, 32'h7FFF_FFFF, 32'h8000_0000, '0, 32'hFFFF_FFFF);
    push_word(masg_pkg::OP_MOVE, 32'h7FFF_FFFF, 32'h8000_0000, '0, 32'hFFFF_FFFF);
    push_word(masg_pkg::OP_TICK, '1, '1, '1, '1);

    // Directed: short moves, a move replacing a move, a set during a move with wrap
    configure(16'd8, 16'd6);
    push_word(masg_pkg::OP_SET, '0, '0, '0, '0);
    push_word(masg_pkg::OP_MOVE, 32'd3, -32'sd2, '0, 32'd5);
    tick_some(15);
    push_word(masg_pkg::OP_MOVE, -32'sd4, 32'd2, 32'd1, -32'sd3);
    tick_until_idle(TICK_CAP);
    push_word(masg_pkg::OP_SET, '0, '0, '0, '0);
    push_word(masg_pkg::OP_MOVE, 32'd4, -32'sd4, 32'd1, '0);
    tick_some(10);
    push_word(masg_pkg::OP_SET, 32'h7FFF_FFFF, 32'h8000_0000, '0, '0);
    tick_until_idle(TICK_CAP);
    push_word(masg_pkg::OP_SET, 32'h8000_0000, 32'h7FFF_FFFF, '0, '0);
    push_word(masg_pkg::OP_MOVE, 32'h7FFF_FFFF, 32'h8000_0000, '0, 32'd1);
    tick_some(20);
    push_word(masg_pkg::OP_SET, '0, '0, '0, '0);
    push_word(masg_pkg::OP_MOVE, '0, '0, '0, '0);
    push_word(masg_pkg::OP_TICK, '0, '0, '0, '0);

    // Random blocks, each with its own register setting and idling pattern
    for (int b = 0; b < 8; b++) begin
      case (b)
        0: configure(16'd8, 16'd1);
        1: configure(16'd8, 16'hFFFF);
        2: configure(16'd12, 16'd9);
        3: configure(16'd10, 16'd3);
        default: configure(16'($urandom_range(16, 8)), 16'($urandom_range(20, 1)));
      endcase
      set_idling(b % 4);
      if (b % 4 == 0) hold_tokens <= hold_tokens + 1;
      run_block(50);
    end

    // Drain and report
    item_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (10) @(posedge clk_i);
    $display("Run covered %0d words and %0d results over four idling patterns", sent_count,
             rx_count);
    $display("with %0d register writes, from the lowest to the highest speed floor", cfg_writes);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS multi_axis_step_generator");
    end else begin
      $display("FAIL multi_axis_step_generator");
    end
    $finish;
  end

endmodule
